[hw/rtl/mf_pkg.sv]
// Shared types and constants for the 3x3 median filter.
// No dependencies; imported by every module of the block but mf_ram.
package mf_pkg;

   // Window geometry
   localparam int WIN_ROWS = 3;
   localparam int WIN_COLS = 3;
   localparam int WIN_TAPS = WIN_ROWS * WIN_COLS;
   localparam int TAP_BITS = $clog2(WIN_TAPS);

   // Median network: nine layers of up to three disjoint compare-exchange ops
   localparam int SORT_LAYERS = 9;
   localparam int LAYER_SLOTS = 3;

   // Pair encoding {lo_index, hi_index}; equal indexes mean an empty slot
   localparam logic [2*TAP_BITS-1:0] PAIR_TABLE [SORT_LAYERS*LAYER_SLOTS] = '{
      8'h12, 8'h45, 8'h78,
      8'h01, 8'h34, 8'h67,
      8'h12, 8'h45, 8'h78,
      8'h03, 8'h58, 8'h47,
      8'h36, 8'h14, 8'h25,
      8'h47, 8'h00, 8'h00,
      8'h42, 8'h00, 8'h00,
      8'h64, 8'h00, 8'h00,
      8'h42, 8'h00, 8'h00
   };

   // Result path
   localparam int OUT_BITS    = 16;
   localparam int FIFO_DEPTH  = 16;
   localparam int CREDIT_BITS = $clog2(FIFO_DEPTH + 1);

   // Register map (index = byte address / 4)
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;
   localparam int   FRAME_WIDTH_BITS  = 11;
   localparam int   FRAME_HEIGHT_BITS = 16;
   localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 16'd1024;

   // Per-transaction control carried down the pipeline
   typedef struct packed {
      logic emit;
      logic border;
      logic last;
   } mf_tag_type;

endpackage

[hw/rtl/median_filter_3x3.sv]
// 3x3 median filter on a raster pixel stream.
// Throughput: one transaction per cycle sustained; req_ready drops once the
//   transactions in flight plus the results waiting in the 16-entry queue reach 16.
//   With rsp_ready held high at most 12 are outstanding (11 stages plus one queued).
// The result of pixel k comes with the transaction of pixel k+W+1 and passes
//   the line store read, the window, the nine sort layers and the result queue
//   before it shows on rsp. Reset is synchronous: counters, window, valid bits,
//   queue cleared, both registers back to 1024; the line store is not cleared.
module median_filter_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // input pixel stream
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [PIXEL_BITS-1:0]         req_pixel_in,
   input  logic                          req_flush,
   // filtered pixel stream
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mf_pkg::OUT_BITS-1:0]   rsp_pixel_out,
   output logic                          rsp_frame_last,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import mf_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);     // column index bits
   localparam int WBITS = $clog2(MAX_WIDTH + 1); // width value bits
   localparam int HBITS = FRAME_HEIGHT_BITS;

   // ---------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------
   logic [FRAME_WIDTH_BITS-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_BITS-1:0] frame_height_ff;
   logic                         csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_pwdata[FRAME_WIDTH_BITS-1:0];
            end
            REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_pwdata[FRAME_HEIGHT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = 32'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = 32'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Effective frame size: zero acts as one, width capped at the line store
   logic [WBITS-1:0] eff_width;
   logic [HBITS-1:0] eff_height;

   always_comb begin
      if (frame_width_ff == '0) begin
         eff_width = WBITS'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         eff_width = WBITS'(MAX_WIDTH);
      end else begin
         eff_width = WBITS'(frame_width_ff);
      end
      eff_height = (frame_height_ff == '0) ? HBITS'(1) : frame_height_ff;
   end

   // ---------------------------------------------------------------------
   // Position counters. All control for a transaction is settled here at
   // accept time and travels down the pipeline as a tag.
   // ---------------------------------------------------------------------
   logic [CW-1:0]    in_col_ff;
   logic [HBITS-1:0] in_row_ff;
   logic [CW-1:0]    out_col_ff;
   logic [HBITS-1:0] out_row_ff;

   logic             req_accept;
   logic [WBITS-1:0] col_w;
   logic [CW-1:0]    col;
   logic             in_col_end;
   logic             out_row_end;
   logic             out_col_end;
   mf_tag_type       acc_tag;
   logic [PIXEL_BITS-1:0] acc_px;

   assign req_accept = req_valid && req_ready;

   always_comb begin
      // a column past a shrunken width wraps as if at the last column
      col_w = (WBITS'(in_col_ff) < eff_width) ? WBITS'(in_col_ff) : eff_width - WBITS'(1);
      col   = col_w[CW-1:0];
      in_col_end  = ((WBITS+1)'(col_w) + (WBITS+1)'(1)) >= (WBITS+1)'(eff_width);
      out_row_end = ((HBITS+1)'(out_row_ff) + (HBITS+1)'(1)) >= (HBITS+1)'(eff_height);
      out_col_end = ((WBITS+1)'(out_col_ff) + (WBITS+1)'(1)) >= (WBITS+1)'(eff_width);

      // first W+1 transactions of a frame fill the window and give nothing
      acc_tag.emit   = (in_row_ff >= HBITS'(2)) || ((in_row_ff == HBITS'(1)) && (col_w != '0));
      acc_tag.border = (out_row_ff == '0) || out_row_end || (out_col_ff == '0) || out_col_end;
      acc_tag.last   = acc_tag.emit && out_row_end && out_col_end;

      acc_px = req_flush ? '0 : req_pixel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (req_accept) begin
         if (acc_tag.emit) begin
            if (acc_tag.last) begin
               out_col_ff <= '0;
               out_row_ff <= '0;
            end else if (out_col_end) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + HBITS'(1);
            end else begin
               out_col_ff <= out_col_ff + CW'(1);
            end
         end
         if (acc_tag.last) begin
            in_col_ff <= '0;
            in_row_ff <= '0;
         end else if (in_col_end) begin
            in_col_ff <= '0;
            if (in_row_ff != '1) begin
               in_row_ff <= in_row_ff + HBITS'(1);
            end
         end else begin
            in_col_ff <= col + CW'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: line store read returns; the column is written back in the
   // cycle after its read. Back-to-back hits on one address (width of one) are
   // forwarded around the RAM.
   // ---------------------------------------------------------------------
   logic                    s1_valid_ff;
   logic [CW-1:0]           s1_col_ff;
   logic [PIXEL_BITS-1:0]   s1_px_ff;
   mf_tag_type              s1_tag_ff;
   logic                    s1_fwd_ff;
   logic [PIXEL_BITS-1:0]   s1_fwd_top_ff;
   logic [PIXEL_BITS-1:0]   s1_fwd_mid_ff;
   logic [2*PIXEL_BITS-1:0] ram_rd_data;
   logic [PIXEL_BITS-1:0]   s1_top;
   logic [PIXEL_BITS-1:0]   s1_mid;
   logic                    fwd_hit;

   assign s1_top  = s1_fwd_ff ? s1_fwd_top_ff : ram_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
   assign s1_mid  = s1_fwd_ff ? s1_fwd_mid_ff : ram_rd_data[PIXEL_BITS-1:0];
   assign fwd_hit = s1_valid_ff && (s1_col_ff == col);

   // each entry holds {row above previous, previous row} for one column
   mf_ram #(
      .WIDTH (2*PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_mid, s1_px_ff}),
      .rd_en   (req_accept),
      .rd_addr (col),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff     <= col;
         s1_px_ff      <= acc_px;
         s1_tag_ff     <= acc_tag;
         s1_fwd_ff     <= fwd_hit;
         s1_fwd_top_ff <= s1_mid;
         s1_fwd_mid_ff <= s1_px_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: window, a row of three column cells shifting right to left.
   // ---------------------------------------------------------------------
   logic [PIXEL_BITS-1:0] new_col [WIN_ROWS];
   logic [PIXEL_BITS-1:0] win_col [WIN_COLS][WIN_ROWS];
   logic [PIXEL_BITS-1:0] win_vec [WIN_TAPS];
   logic                  w_valid_ff;
   mf_tag_type            w_tag_ff;

   assign new_col[0] = s1_top;
   assign new_col[1] = s1_mid;
   assign new_col[2] = s1_px_ff;

   for (genvar c = 0; c < WIN_COLS; c++) begin : g_win
      if (c == WIN_COLS - 1) begin : g_head
         mf_window_col #(.PIXEL_BITS(PIXEL_BITS)) u_col (
            .clock    (clock),
            .reset    (reset),
            .shift_en (s1_valid_ff),
            .data_in  (new_col),
            .data_out (win_col[c])
         );
      end else begin : g_body
         mf_window_col #(.PIXEL_BITS(PIXEL_BITS)) u_col (
            .clock    (clock),
            .reset    (reset),
            .shift_en (s1_valid_ff),
            .data_in  (win_col[c+1]),
            .data_out (win_col[c])
         );
      end
   end

   always_comb begin
      for (int r = 0; r < WIN_ROWS; r++) begin
         for (int c = 0; c < WIN_COLS; c++) begin
            win_vec[r*WIN_COLS + c] = win_col[c][r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
      end else begin
         w_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      w_tag_ff <= s1_tag_ff;
   end

   // ---------------------------------------------------------------------
   // Stages 3..11: median network, one registered layer per cell. The
   // center sample rides along for border pixels.
   // ---------------------------------------------------------------------
   logic                  cell_valid  [SORT_LAYERS];
   mf_tag_type            cell_tag    [SORT_LAYERS];
   logic [PIXEL_BITS-1:0] cell_center [SORT_LAYERS];
   logic [PIXEL_BITS-1:0] cell_vec    [SORT_LAYERS][WIN_TAPS];

   for (genvar i = 0; i < SORT_LAYERS; i++) begin : g_sort
      if (i == 0) begin : g_first
         mf_sort_cell #(.PIXEL_BITS(PIXEL_BITS), .LAYER(i)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .valid_in   (w_valid_ff),
            .tag_in     (w_tag_ff),
            .center_in  (win_col[1][1]),
            .vec_in     (win_vec),
            .valid_out  (cell_valid[i]),
            .tag_out    (cell_tag[i]),
            .center_out (cell_center[i]),
            .vec_out    (cell_vec[i])
         );
      end else begin : g_next
         mf_sort_cell #(.PIXEL_BITS(PIXEL_BITS), .LAYER(i)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .valid_in   (cell_valid[i-1]),
            .tag_in     (cell_tag[i-1]),
            .center_in  (cell_center[i-1]),
            .vec_in     (cell_vec[i-1]),
            .valid_out  (cell_valid[i]),
            .tag_out    (cell_tag[i]),
            .center_out (cell_center[i]),
            .vec_out    (cell_vec[i])
         );
      end
   end

   // ---------------------------------------------------------------------
   // Result select and queue. A credit counts every accepted transaction
   // until it is popped, or dropped at the end of the chain for giving no
   // result, so the queue can never overflow.
   // ---------------------------------------------------------------------
   logic                         end_valid;
   mf_tag_type                   end_tag;
   logic [PIXEL_BITS-1:0]        end_px;
   logic [PIXEL_BITS+OUT_BITS-1:0] end_px_ext;
   logic                         fifo_push;
   logic                         drop;
   logic                         rsp_accept;
   logic [OUT_BITS:0]            fifo_out;
   logic [CREDIT_BITS-1:0]       credit_ff;
   logic [CREDIT_BITS-1:0]       credit_in;

   assign end_valid  = cell_valid[SORT_LAYERS-1];
   assign end_tag    = cell_tag[SORT_LAYERS-1];
   assign end_px     = end_tag.border ? cell_center[SORT_LAYERS-1]
                                      : cell_vec[SORT_LAYERS-1][WIN_TAPS/2];
   assign end_px_ext = {{OUT_BITS{1'b0}}, end_px};
   assign fifo_push  = end_valid && end_tag.emit;
   assign drop       = end_valid && !end_tag.emit;
   assign rsp_accept = rsp_valid && rsp_ready;

   mf_out_fifo #(.WIDTH(OUT_BITS + 1)) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data ({end_tag.last, end_px_ext[OUT_BITS-1:0]}),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (fifo_out)
   );

   assign rsp_pixel_out  = fifo_out[OUT_BITS-1:0];
   assign rsp_frame_last = fifo_out[OUT_BITS];

   assign credit_in = credit_ff + CREDIT_BITS'(req_accept)
                    - CREDIT_BITS'(rsp_accept) - CREDIT_BITS'(drop);
   assign req_ready = credit_ff < CREDIT_BITS'(FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

endmodule

[hw/rtl/mf_ram.sv]
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module mf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mf_window_col.sv]
// One column of the 3x3 window: three samples, shifted to the left neighbor.
// Depends on mf_pkg.
module mf_window_col #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic [PIXEL_BITS-1:0] data_in  [mf_pkg::WIN_ROWS],
   output logic [PIXEL_BITS-1:0] data_out [mf_pkg::WIN_ROWS]
);
   import mf_pkg::*;

   logic [PIXEL_BITS-1:0] sample_ff [WIN_ROWS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < WIN_ROWS; r++) begin
            sample_ff[r] <= '0;
         end
      end else if (shift_en) begin
         for (int r = 0; r < WIN_ROWS; r++) begin
            sample_ff[r] <= data_in[r];
         end
      end
   end

   assign data_out = sample_ff;

endmodule

[hw/rtl/mf_sort_cell.sv]
// One layer of the median network: disjoint compare-exchanges, registered.
// Depends on mf_pkg (pair table, tag type).
module mf_sort_cell #(
   parameter int PIXEL_BITS = 16,
   parameter int LAYER      = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      valid_in,
   input  mf_pkg::mf_tag_type        tag_in,
   input  logic [PIXEL_BITS-1:0]     center_in,
   input  logic [PIXEL_BITS-1:0]     vec_in  [mf_pkg::WIN_TAPS],
   output logic                      valid_out,
   output mf_pkg::mf_tag_type        tag_out,
   output logic [PIXEL_BITS-1:0]     center_out,
   output logic [PIXEL_BITS-1:0]     vec_out [mf_pkg::WIN_TAPS]
);
   import mf_pkg::*;

   logic                  valid_ff;
   mf_tag_type            tag_ff;
   logic [PIXEL_BITS-1:0] center_ff;
   logic [PIXEL_BITS-1:0] vec_ff [WIN_TAPS];
   logic [PIXEL_BITS-1:0] vec_in_sorted [WIN_TAPS];

   always_comb begin
      logic [2*TAP_BITS-1:0] pair;
      logic [TAP_BITS-1:0]   lo_sel;
      logic [TAP_BITS-1:0]   hi_sel;
      logic [PIXEL_BITS-1:0] a_val;
      logic [PIXEL_BITS-1:0] b_val;
      vec_in_sorted = vec_in;
      for (int s = 0; s < LAYER_SLOTS; s++) begin
         pair   = PAIR_TABLE[LAYER*LAYER_SLOTS + s];
         lo_sel = pair[2*TAP_BITS-1:TAP_BITS];
         hi_sel = pair[TAP_BITS-1:0];
         a_val  = vec_in_sorted[lo_sel];
         b_val  = vec_in_sorted[hi_sel];
         if (a_val > b_val) begin
            vec_in_sorted[lo_sel] = b_val;
            vec_in_sorted[hi_sel] = a_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff    <= tag_in;
      center_ff <= center_in;
      vec_ff    <= vec_in_sorted;
   end

   assign valid_out  = valid_ff;
   assign tag_out    = tag_ff;
   assign center_out = center_ff;
   assign vec_out    = vec_ff;

endmodule

[hw/rtl/mf_out_fifo.sv]
// Result queue in front of the rsp channel; never pushed when full.
// Depends on mf_pkg (FIFO_DEPTH).
module mf_out_fifo #(
   parameter int WIDTH = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import mf_pkg::*;

   localparam int PTR_BITS = $clog2(FIFO_DEPTH);

   logic [WIDTH-1:0]       mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff;
   logic [PTR_BITS-1:0]    rd_ptr_ff;
   logic [CREDIT_BITS-1:0] count_ff;
   logic [CREDIT_BITS-1:0] count_in;
   logic                   pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign count_in  = count_ff + CREDIT_BITS'(push) - CREDIT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[tb/tb_median_filter_3x3.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 median filter: directed frames, then random frames.
// Depends on mf_pkg and median_filter_3x3 from the RTL; nothing else.
module tb_median_filter_3x3;
   import mf_pkg::*;

   localparam int MAX_W = 1024;
   localparam int LATENCY_WAIT = 40;   // covers the pipeline plus slack
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the result queue
   localparam int PHASE_ITEMS = 80;

   typedef struct packed {
      logic [15:0] pixel;
      logic        flush;
   } pixel_item_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] pixel;
      logic                last;
   } filtered_pixel_type;

   // ---------------------------------------------------------------- DUT ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_pixel_in = '0;
   logic        req_flush = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [OUT_BITS-1:0] rsp_pixel_out;
   logic        rsp_frame_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   median_filter_3x3 #(
      .MAX_WIDTH  (MAX_W),
      .PIXEL_BITS (16)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_in   (req_pixel_in),
      .req_flush      (req_flush),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------- shared state
   pixel_item_type     pixel_feed[$];       // transactions waiting for the driver
   filtered_pixel_type expected_pixels[$];  // predicted results, oldest first
   int unsigned     fail_count = 0;
   int unsigned     queued_count = 0;
   int unsigned     send_idle_pct = 33;
   int unsigned     recv_idle_pct = 72;
   bit              hold_req = 1'b0;

   // Filter model state. Registers mirror the DUT's; the rest is the pipeline
   // as the stream sees it (two line stores, 3x3 taps, input/output position).
   logic [FRAME_WIDTH_BITS-1:0]  frame_w_reg = FRAME_WIDTH_RESET;
   logic [FRAME_HEIGHT_BITS-1:0] frame_h_reg = FRAME_HEIGHT_RESET;
   logic [15:0] line_mem [2*MAX_W];      // [0..MAX_W) newest row, above that the older row
   logic [15:0] taps [9];                // row-major, column 2 is the newest
   int unsigned feed_row, feed_col, emit_row, emit_col;

   function automatic int unsigned width_in_use();
      if (frame_w_reg == 0) return 1;
      if (frame_w_reg > MAX_W) return MAX_W;
      return 32'(frame_w_reg);
   endfunction

   function automatic int unsigned height_in_use();
      return (frame_h_reg == 0) ? 1 : 32'(frame_h_reg);
   endfunction

   // Advance the model by one accepted transaction; queue a result if one is due.
   task automatic filter_pixel(input logic [15:0] pixel_in, input logic is_flush);
      int unsigned w, h, col;
      int          i, j, lt, le;
      logic [15:0] px, top, mid, val;
      logic        emit, border, last, found;
      filtered_pixel_type res;
      w = width_in_use();
      h = height_in_use();
      px = is_flush ? 16'd0 : pixel_in;
      // a column past a shrunk width is treated as the last column
      col = (feed_col < w) ? feed_col : w - 1;

      top = line_mem[MAX_W + col];
      mid = line_mem[col];
      line_mem[MAX_W + col] = mid;
      line_mem[col] = px;
      for (i = 0; i < 3; i++) begin
         taps[i*3] = taps[i*3 + 1];
         taps[i*3 + 1] = taps[i*3 + 2];
      end
      taps[2] = top;
      taps[5] = mid;
      taps[8] = px;

      // output trails input by one line plus one pixel
      emit = (feed_row >= 2) || (feed_row == 1 && col >= 1);
      last = 1'b0;
      if (emit) begin
         border = (emit_row == 0) || (emit_row + 1 >= h) ||
                  (emit_col == 0) || (emit_col + 1 >= w);
         val = taps[4];
         if (!border) begin
            // median = the tap with at most four smaller and at least five not larger
            found = 1'b0;
            for (i = 0; i < 9; i++) begin
               lt = 0;
               le = 0;
               for (j = 0; j < 9; j++) begin
                  if (taps[j] < taps[i]) lt++;
                  if (taps[j] <= taps[i]) le++;
               end
               if (!found && lt <= 4 && le >= 5) begin
                  val = taps[i];
                  found = 1'b1;
               end
            end
         end
         last = (emit_row + 1 >= h) && (emit_col + 1 >= w);
         res.pixel = val;
         res.last = last;
         expected_pixels = {expected_pixels, res};
         if (last) begin
            emit_row = 0;
            emit_col = 0;
         end else if (emit_col + 1 >= w) begin
            emit_col = 0;
            emit_row = (emit_row + 1) & 16'hFFFF;
         end else begin
            emit_col++;
         end
      end

      if (last) begin
         feed_row = 0;
         feed_col = 0;
      end else if (col + 1 >= w) begin
         feed_col = 0;
         if (feed_row < 16'hFFFF) feed_row++;
      end else begin
         feed_col = col + 1;
      end
   endtask

   // ---------------------------------------------------------------- driver
   // Offers the next queued pixel when the slot is free and a random idle draw
   // allows it; the model is advanced at the edge where the transaction is taken.
   always @(posedge clock) begin : driver
      pixel_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_pixel_in <= '0;
         req_flush <= 1'b0;
         foreach (line_mem[k]) line_mem[k] = '0;
         foreach (taps[k]) taps[k] = '0;
         feed_row = 0;
         feed_col = 0;
         emit_row = 0;
         emit_col = 0;
      end else begin
         if (req_valid && req_ready) filter_pixel(req_pixel_in, req_flush);
         if (!req_valid || req_ready) begin
            if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pixel_feed.pop_front();
               req_valid <= 1'b1;
               req_pixel_in <= nxt.pixel;
               req_flush <= nxt.flush;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   // Checks each result against the oldest prediction and throttles rsp_ready.
   // One long hold-off on request lets the block back up into req_ready.
   always @(posedge clock) begin : monitor
      filtered_pixel_type want;
      int unsigned     hold_left;
      bit              hold_taken;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         hold_taken = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result pixel_out=%0d frame_last=%0b",
                        $time, rsp_pixel_out, rsp_frame_last);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_out !== want.pixel) begin
                  $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                           $time, want.pixel, rsp_pixel_out);
                  fail_count++;
               end
               if (rsp_frame_last !== want.last) begin
                  $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                           $time, want.last, rsp_frame_last);
                  fail_count++;
               end
            end
         end
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------- stimulus
   task automatic queue_pixel(input logic [15:0] pixel, input logic flush);
      pixel_item_type it;
      it.pixel = pixel;
      it.flush = flush;
      pixel_feed = {pixel_feed, it};
      queued_count++;
   endtask

   // Half full-range values, with runs of ties and values at both ends.
   function automatic logic [15:0] pick_pixel();
      case ($urandom_range(0, 7))
         4:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         5, 6:    return 16'($urandom_range(0, 7));
         7:       return 16'hFFFF - 16'($urandom_range(0, 7));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // W*H pixels (a few stray flush transactions mixed in), then tail flushes.
   task automatic queue_frame(input int unsigned w, input int unsigned h,
                              input int unsigned tail);
      int unsigned i;
      for (i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 39) == 0) queue_pixel(pick_pixel(), 1'b1);
         else queue_pixel(pick_pixel(), 1'b0);
      end
      for (i = 0; i < tail; i++) queue_pixel(pick_pixel(), 1'b1);
   endtask

   task automatic wait_sent();
      while (pixel_feed.size() != 0 || req_valid) @(negedge clock);
   endtask

   // Everything accepted, every result back, and the pipe drained of
   // transactions that carry no result.
   task automatic settle();
      wait_sent();
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (LATENCY_WAIT) @(negedge clock);
   endtask

   // Flush one transaction at a time until the model is back at a frame start.
   task automatic close_frame();
      wait_sent();
      while (feed_row != 0 || feed_col != 0 || emit_row != 0 || emit_col != 0) begin
         queue_pixel(pick_pixel(), 1'b1);
         wait_sent();
      end
   endtask

   // APB write: setup, access, register lands at the edge ending the access.
   // Bits above the register width carry junk; the block must drop them.
   task automatic csr_write(input logic reg_idx, input int unsigned value);
      logic [31:0] mask;
      mask = (reg_idx == REG_FRAME_WIDTH) ? (32'd1 << FRAME_WIDTH_BITS) - 1
                                          : (32'd1 << FRAME_HEIGHT_BITS) - 1;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= ($urandom() & ~mask) | (value & mask);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_idx == REG_FRAME_WIDTH) frame_w_reg = FRAME_WIDTH_BITS'(value & mask);
      else frame_h_reg = FRAME_HEIGHT_BITS'(value & mask);
   endtask

   task automatic set_frame(input int unsigned w, input int unsigned h);
      close_frame();
      settle();
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
   endtask

   // One register setting, one to three frames. Some frames lose their
   // flushes (the next frame drains them), some get too few or too many.
   task automatic random_group();
      int unsigned w_set, h_set, w, h, frames, f, tail;
      case ($urandom_range(0, 9))
         0:       w_set = $urandom_range(0, 2);
         1:       w_set = $urandom_range(13, 40);
         default: w_set = $urandom_range(3, 12);
      endcase
      if (w_set > 12) h_set = $urandom_range(1, 4);
      else if ($urandom_range(0, 7) == 0) h_set = $urandom_range(0, 2);
      else h_set = $urandom_range(3, 8);
      set_frame(w_set, h_set);
      w = width_in_use();
      h = height_in_use();
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
         case ($urandom_range(0, 9))
            7:       tail = 0;
            8:       tail = $urandom_range(0, w);
            9:       tail = w + 1 + $urandom_range(1, 3);
            default: tail = w + 1;
         endcase
         queue_frame(w, h, tail);
      end
   endtask

   initial begin : stimulus
      int unsigned phase, phase_start, i, guard;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---
      // 3x3 frame: one interior pixel, extremes around it; flush pixels are ignored
      set_frame(3, 3);
      queue_pixel(16'hFFFF, 1'b0); queue_pixel(16'h0000, 1'b0); queue_pixel(16'd7, 1'b0);
      queue_pixel(16'd300, 1'b0);  queue_pixel(16'hFFFF, 1'b0); queue_pixel(16'd12, 1'b0);
      queue_pixel(16'h0000, 1'b0); queue_pixel(16'd9, 1'b0);    queue_pixel(16'd40000, 1'b0);
      queue_pixel(16'hFFFF, 1'b1); queue_pixel(16'h5A5A, 1'b1);
      queue_pixel(16'h0000, 1'b1); queue_pixel(16'hA5A5, 1'b1);
      // zero width and height act as 1: single-pixel frame
      set_frame(0, 0);
      queue_pixel(16'h8001, 1'b0);
      queue_pixel(16'h7FFE, 1'b1);
      queue_pixel(16'hFFFF, 1'b1);
      // 2x2 frames, all border; first frame has no flush, the second drains it
      set_frame(2, 2);
      for (i = 1; i <= 8; i++) queue_pixel(16'(i), 1'b0);
      for (i = 0; i < 3; i++) queue_pixel(16'h1234, 1'b1);

      // tallest height, then cut short mid frame: next result ends the frame
      set_frame(1, 65535);
      for (i = 0; i < 40; i++) queue_pixel(pick_pixel(), 1'b0);
      settle();
      csr_write(REG_FRAME_HEIGHT, 3);
      close_frame();

      // width shrinks mid frame, with the input column at the new last column
      set_frame(8, 5);
      queue_frame(8, 5, 9);
      for (i = 0; i < 20; i++) queue_pixel(pick_pixel(), 1'b0);
      settle();
      csr_write(REG_FRAME_WIDTH, 5);
      close_frame();

      // --- random, three idling regimes ---
      for (phase = 0; phase < 3; phase++) begin
         settle();
         case (phase)
            0: begin send_idle_pct = 33; recv_idle_pct = 72; end
            1: begin send_idle_pct = 72; recv_idle_pct = 33; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (phase == 2) begin
            // receiver stops for a long stretch while a tall frame streams in
            set_frame(4, 24);
            hold_req = 1'b1;
            queue_frame(4, 24, 5);
         end
         phase_start = queued_count;
         while (queued_count - phase_start < PHASE_ITEMS) random_group();
      end

      // --- wrap up ---
      wait_sent();
      guard = 0;
      while (expected_pixels.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (LATENCY_WAIT) @(negedge clock);
      if (expected_pixels.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_pixels.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
hw/rtl/mf_pkg.sv
hw/rtl/mf_ram.sv
hw/rtl/mf_window_col.sv
hw/rtl/mf_sort_cell.sv
hw/rtl/mf_out_fifo.sv
hw/rtl/median_filter_3x3.sv
tb/tb_median_filter_3x3.sv
